// ===== hw/rtl/fnp_pkg.sv =====
// Shared types and constants for the format specifier number printer.
// Used by fnp_front, fnp_back and the top level; no dependencies.
package fnp_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int VAL_W          = 32;
    localparam int CNT_W          = 16;
    localparam int CHAR_W         = 8;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CHAR_W-1:0] OP_CHAR  = 8'h63;  // 'c'
    localparam logic [CHAR_W-1:0] OP_DEC   = 8'h64;  // 'd'
    localparam logic [CHAR_W-1:0] OP_INT   = 8'h69;  // 'i'
    localparam logic [CHAR_W-1:0] OP_BIN   = 8'h62;  // 'b'
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;  // '-'

    typedef enum logic [1:0] {
        K_ONE = 2'd0,   // character, empty character or error: one result
        K_DEC = 2'd1,
        K_BIN = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic              neg;
        logic              err;
        logic [VAL_W-1:0]  data;   // char byte, magnitude or binary value
        logic [CNT_W-1:0]  prior;
    } t_cmd;

endpackage

// ===== hw/rtl/fnp_front.sv =====
// Front end: accepts input transactions, classifies the format character
// and queues one command per item. Depends on fnp_pkg.
module fnp_front #(
    parameter int VALUE_BITS = fnp_pkg::VALUE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [fnp_pkg::CHAR_W-1:0]  i_operation,
    input  logic [fnp_pkg::VAL_W-1:0]   i_value,
    input  logic [fnp_pkg::CNT_W-1:0]   i_prior_count,
    output logic                        o_cmd_valid,
    output fnp_pkg::t_cmd               o_cmd,
    input  logic                        i_cmd_pop
);

    localparam int EFF = (VALUE_BITS < fnp_pkg::VAL_W) ? VALUE_BITS : fnp_pkg::VAL_W;
    localparam bit HAS_SIGN = (VALUE_BITS <= fnp_pkg::VAL_W);
    localparam logic [fnp_pkg::VAL_W-1:0] MASK = {fnp_pkg::VAL_W{1'b1}} >> (fnp_pkg::VAL_W - EFF);
    localparam int CW = $clog2(fnp_pkg::QUEUE_DEPTH + 1);
    localparam int PW = $clog2(fnp_pkg::QUEUE_DEPTH);

    fnp_pkg::t_cmd            r_mem [fnp_pkg::QUEUE_DEPTH];
    logic [PW-1:0]            r_wp, r_rp;
    logic [CW-1:0]            r_cnt;
    fnp_pkg::t_cmd            w_cmd;
    logic [fnp_pkg::VAL_W-1:0] w_v;
    logic                     w_push;

    always_comb begin
        w_v          = i_value & MASK;
        w_cmd.kind   = fnp_pkg::K_ONE;
        w_cmd.neg    = 1'b0;
        w_cmd.err    = 1'b0;
        w_cmd.data   = '0;
        w_cmd.prior  = i_prior_count;
        case (i_operation)
            fnp_pkg::OP_CHAR: begin
                w_cmd.data = {{(fnp_pkg::VAL_W - fnp_pkg::CHAR_W){1'b0}}, w_v[7:0]};
            end
            fnp_pkg::OP_DEC, fnp_pkg::OP_INT: begin
                w_cmd.kind = fnp_pkg::K_DEC;
                w_cmd.neg  = HAS_SIGN && w_v[EFF-1];
                // two's complement magnitude; the most negative value stays in range
                w_cmd.data = w_cmd.neg ? ((~w_v + 1'b1) & MASK) : w_v;
            end
            fnp_pkg::OP_BIN: begin
                w_cmd.kind = fnp_pkg::K_BIN;
                w_cmd.data = w_v;
            end
            default: begin
                w_cmd.err = 1'b1;
            end
        endcase
    end

    assign o_ready     = (r_cnt != CW'(fnp_pkg::QUEUE_DEPTH));
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({w_push, i_cmd_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_cmd;
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(fnp_pkg::QUEUE_DEPTH))
        else $error("command queue overfilled");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> r_cnt != '0)
        else $error("pop from empty command queue");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !i_cmd_pop) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count missed a push");

endmodule

// ===== hw/rtl/fnp_back.sv =====
// Back end: carries out queued commands, emitting one character per
// output transaction through a registered output stage. Depends on fnp_pkg.
module fnp_back #(
    parameter int VALUE_BITS = fnp_pkg::VALUE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  fnp_pkg::t_cmd               i_cmd,
    output logic                        o_cmd_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [fnp_pkg::CHAR_W-1:0]  o_char,
    output logic                        o_char_valid,
    output logic                        o_last,
    output logic [fnp_pkg::CNT_W-1:0]   o_total,
    output logic                        o_status
);

    localparam int EFF   = (VALUE_BITS < fnp_pkg::VAL_W) ? VALUE_BITS : fnp_pkg::VAL_W;
    localparam int SHIFT = fnp_pkg::VAL_W - EFF;
    localparam int DIGS  = 10;               // decimal digits of a 32-bit magnitude
    localparam int SPW   = $clog2(DIGS + 1);
    localparam int BCW   = $clog2(fnp_pkg::VAL_W + 1);
    localparam logic [63:0] RECIP10 = 64'h0000_0000_CCCC_CCCD;  // ceil(2^35 / 10)

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ONE   = 7'b0000010,
        S_CONV  = 7'b0000100,
        S_DSIGN = 7'b0001000,
        S_DDIG  = 7'b0010000,
        S_SKIP  = 7'b0100000,
        S_BEMIT = 7'b1000000
    } t_state;

    t_state                     r_state, n_state;
    logic [fnp_pkg::VAL_W-1:0]  r_mag, n_mag;
    logic                       r_neg, n_neg;
    logic                       r_err, n_err;
    logic [fnp_pkg::CNT_W-1:0]  r_total, n_total;
    logic [SPW-1:0]             r_sp, n_sp;
    logic [3:0]                 r_stack [DIGS];
    logic [BCW-1:0]             r_bcnt, n_bcnt;

    logic                       r_ovalid;
    logic [fnp_pkg::CHAR_W-1:0] r_ochar;
    logic                       r_ocv, r_olast, r_ostat;
    logic [fnp_pkg::CNT_W-1:0]  r_ototal;

    logic                       w_free, w_emit;
    logic [fnp_pkg::CHAR_W-1:0] e_char;
    logic                       e_cv, e_last, e_stat;
    logic [fnp_pkg::CNT_W-1:0]  e_total, w_inc;
    logic [63:0]                w_prod;
    logic [fnp_pkg::VAL_W-1:0]  w_quot, w_q10, w_rem;
    logic [3:0]                 w_top;
    logic                       w_has;

    assign w_free = !r_ovalid || i_ready;
    assign w_inc  = (r_total == {fnp_pkg::CNT_W{1'b1}}) ? r_total : r_total + 1'b1;

    // divide by ten through the reciprocal, exact for 32-bit operands
    assign w_prod = {32'b0, r_mag} * RECIP10;
    assign w_quot = {3'b0, w_prod[63:35]};
    assign w_q10  = {w_quot[fnp_pkg::VAL_W-4:0], 3'b0} + {w_quot[fnp_pkg::VAL_W-2:0], 1'b0};
    assign w_rem  = r_mag - w_q10;
    assign w_top  = r_stack[r_sp - 1'b1];
    assign w_has  = (r_mag[7:0] != '0) && !r_err;

    always_comb begin
        n_state   = r_state;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_err     = r_err;
        n_total   = r_total;
        n_sp      = r_sp;
        n_bcnt    = r_bcnt;
        o_cmd_pop = 1'b0;
        w_emit    = 1'b0;
        e_char    = '0;
        e_cv      = 1'b1;
        e_last    = 1'b0;
        e_stat    = 1'b0;
        e_total   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_total   = i_cmd.prior;
                    n_neg     = i_cmd.neg;
                    n_err     = i_cmd.err;
                    n_sp      = '0;
                    case (i_cmd.kind)
                        fnp_pkg::K_DEC: begin
                            n_mag   = i_cmd.data;
                            n_state = S_CONV;
                        end
                        fnp_pkg::K_BIN: begin
                            n_mag   = i_cmd.data << SHIFT;
                            n_bcnt  = BCW'(EFF);
                            n_state = S_SKIP;
                        end
                        default: begin
                            n_mag   = i_cmd.data;
                            n_state = S_ONE;
                        end
                    endcase
                end
            end
            S_ONE: begin
                if (w_free) begin
                    w_emit  = 1'b1;
                    e_char  = w_has ? r_mag[7:0] : '0;
                    e_cv    = w_has;
                    e_last  = 1'b1;
                    e_stat  = r_err;
                    e_total = w_has ? w_inc : r_total;
                    n_state = S_IDLE;
                end
            end
            S_CONV: begin
                n_mag = w_quot;
                n_sp  = r_sp + 1'b1;
                if (w_quot == '0) begin
                    n_state = r_neg ? S_DSIGN : S_DDIG;
                end
            end
            S_DSIGN: begin
                if (w_free) begin
                    w_emit  = 1'b1;
                    e_char  = fnp_pkg::CH_MINUS;
                    n_total = w_inc;
                    n_state = S_DDIG;
                end
            end
            S_DDIG: begin
                if (w_free) begin
                    w_emit  = 1'b1;
                    e_char  = fnp_pkg::CH_ZERO | {4'b0, w_top};
                    e_last  = (r_sp == SPW'(1));
                    e_total = e_last ? w_inc : '0;
                    n_total = w_inc;
                    n_sp    = r_sp - 1'b1;
                    if (e_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SKIP: begin
                // drop leading zeros; the final bit always prints
                if (!r_mag[fnp_pkg::VAL_W-1] && r_bcnt > BCW'(1)) begin
                    n_mag  = r_mag << 1;
                    n_bcnt = r_bcnt - 1'b1;
                end else begin
                    n_state = S_BEMIT;
                end
            end
            S_BEMIT: begin
                if (w_free) begin
                    w_emit  = 1'b1;
                    e_char  = fnp_pkg::CH_ZERO | {7'b0, r_mag[fnp_pkg::VAL_W-1]};
                    e_last  = (r_bcnt == BCW'(1));
                    e_total = e_last ? w_inc : '0;
                    n_total = w_inc;
                    n_mag   = r_mag << 1;
                    n_bcnt  = r_bcnt - 1'b1;
                    if (e_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_sp     <= '0;
            r_bcnt   <= '0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            r_bcnt  <= n_bcnt;
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_err   <= n_err;
        r_total <= n_total;
        if (r_state == S_CONV) begin
            r_stack[r_sp] <= w_rem[3:0];
        end
        if (w_emit) begin
            r_ochar  <= e_char;
            r_ocv    <= e_cv;
            r_olast  <= e_last;
            r_ostat  <= e_stat;
            r_ototal <= e_total;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_char       = r_ochar;
    assign o_char_valid = r_ocv;
    assign o_last       = r_olast;
    assign o_total      = r_ototal;
    assign o_status     = r_ostat;

    a_digit_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DDIG) |-> (r_sp != '0 && r_sp <= SPW'(DIGS)))
        else $error("digit stack empty or overfull while printing");

    a_bits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BEMIT || r_state == S_SKIP) |-> r_bcnt != '0)
        else $error("binary bit count ran out");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |=> (r_ovalid && $stable(r_ochar) && $stable(r_olast)))
        else $error("pending result overwritten");

endmodule

// ===== hw/rtl/format_specifier_number_printer.sv =====
// Format specifier number printer: 'c', 'd'/'i' and 'b' conversions to ASCII.
// Items pass through the command queue, back-end state machine and registered
// output stage; decimal conversion takes one divide-by-ten step per cycle. The
// queue takes items while the back end is busy until full; the back end pops a
// command only when idle and shifts binary bits out one per cycle unless stalled.
// Reset: synchronous; the command queue empties and no result is pending.
module format_specifier_number_printer #(
    parameter int VALUE_BITS = fnp_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // value [31:0], prior_count [47:32]
    input  logic [7:0]  s_axis_tuser,   // operation [7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_char [7:0], total_count [23:8]
    output logic [1:0]  m_axis_tuser,   // char_valid [0], status [1]
    output logic        m_axis_tlast
);

    logic          w_cmd_valid, w_cmd_pop;
    fnp_pkg::t_cmd w_cmd;

    fnp_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_operation   (s_axis_tuser),
        .i_value       (s_axis_tdata[31:0]),
        .i_prior_count (s_axis_tdata[47:32]),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_cmd_pop     (w_cmd_pop)
    );

    fnp_back #(
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_cmd_valid),
        .i_cmd        (w_cmd),
        .o_cmd_pop    (w_cmd_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_char       (m_axis_tdata[7:0]),
        .o_char_valid (m_axis_tuser[0]),
        .o_last       (m_axis_tlast),
        .o_total      (m_axis_tdata[23:8]),
        .o_status     (m_axis_tuser[1])
    );

endmodule
